// ===== hdl/pha_pkg.sv =====
package pha_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd2;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_PAGE   = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_NOT_OWNED = 3'd4;
  localparam logic [2:0] ST_RELEASED  = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Header entry: free flag on top of a 9-bit data size.
  typedef struct packed {
    logic       free;
    logic [8:0] size;
  } hdr_t;

  // Free byte count plus an addend, saturating at the field maximum.
  function automatic logic [8:0] sat_add(input logic [8:0] v, input logic [9:0] a);
    logic [10:0] s;
    s = 11'(v) + 11'(a);
    sat_add = (s > 11'd511) ? 9'd511 : s[8:0];
  endfunction

endpackage

// ===== hdl/pha_hdr_mem.sv =====
module pha_hdr_mem #(
  parameter int AW = 12
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  pha_pkg::hdr_t      wdata,
  input  logic [AW-1:0]      raddr,
  output pha_pkg::hdr_t      rdata
);

  pha_pkg::hdr_t mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pha_div.sv =====
module pha_div #(
  parameter int DW = 18,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW-1:0]    q_r;
  logic [VW-1:0]    r_r;
  logic [VW-1:0]    d_r;
  logic [VW:0]      trial;
  logic             fits;

  assign trial = {r_r, q_r[DW-1]};
  assign fits  = trial >= {1'b0, d_r};

  // One quotient bit per cycle, restoring form.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        r_r   <= fits ? VW'(trial - {1'b0, d_r}) : trial[VW-1:0];
        q_r   <= {q_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== hdl/paged_heap_first_fit_allocator.sv =====
// Paged heap allocator, first fit with coalescing on free.
// Input channel (in_valid/in_ready) carries one request per beat: an
// allocation of in_request_size bytes or a free of in_block_pointer. The
// result channel (out_valid/out_ready) returns exactly one beat per request
// with status, data pointer, released page and freed byte count.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must be issued only while the block is idle; the block itself does not enforce
// this. Writing the first page number also loads the page counter.
// One request is processed at a time. An allocation scans the page table
// slots and visits the headers in each candidate page. A free first runs
// the divider to split the pointer into page and offset, then scans the
// slots and walks the page header chain twice. The header store has one
// read and one write port, which sets the walk rate.
// in_ready is high whenever the sequencer is idle, even while a result beat
// waits for out_ready; a finished request holds in its last step until the
// output register is free. Reset empties the page table, loads the default
// configuration and clears the page counter; the header store is not cleared.
module paged_heap_first_fit_allocator #(
  parameter int HEAP_SLOTS     = 16,
  parameter int MAX_PAGE_BYTES = 256,
  parameter int HEADER_BYTES   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [8:0]                     in_request_size,
  input  logic [17:0]                    in_block_pointer,
  input  logic                           in_page_granted,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [17:0]                    out_data_pointer,
  output logic [9:0]                     out_released_page,
  output logic [8:0]                     out_freed_bytes,
  input  logic                           cfg_we,
  input  logic [pha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pha_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW  = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
  localparam int OW  = (MAX_PAGE_BYTES > 1) ? $clog2(MAX_PAGE_BYTES) : 1;
  localparam int PSW = $clog2(MAX_PAGE_BYTES + 1);
  localparam int CW  = (PSW > 9) ? PSW : 9;
  localparam int AW  = CW + 2;
  localparam int PW  = 10 + PSW;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_A_SCAN    = 5'd1;
  localparam logic [4:0] S_A_NEXT    = 5'd2;
  localparam logic [4:0] S_A_RD      = 5'd3;
  localparam logic [4:0] S_A_CHK     = 5'd4;
  localparam logic [4:0] S_A_NEW     = 5'd5;
  localparam logic [4:0] S_A_WR2     = 5'd6;
  localparam logic [4:0] S_MUL       = 5'd7;
  localparam logic [4:0] S_PTR       = 5'd8;
  localparam logic [4:0] S_F_DIV     = 5'd9;
  localparam logic [4:0] S_F_FIND    = 5'd10;
  localparam logic [4:0] S_F_WALK    = 5'd11;
  localparam logic [4:0] S_F_WCHK    = 5'd12;
  localparam logic [4:0] S_F_HCHK    = 5'd13;
  localparam logic [4:0] S_F_RCHK    = 5'd14;
  localparam logic [4:0] S_F_L       = 5'd15;
  localparam logic [4:0] S_F_LCHK    = 5'd16;
  localparam logic [4:0] S_F_NXCHK   = 5'd17;
  localparam logic [4:0] S_F_END     = 5'd18;
  localparam logic [4:0] S_DONE      = 5'd19;

  localparam logic [SW-1:0] LAST_SLOT = SW'(HEAP_SLOTS - 1);

  logic [4:0]     state_r;
  logic [8:0]     page_size_r;
  logic [7:0]     process_id_r;
  logic [9:0]     pc_r;

  logic           pt_valid_r [HEAP_SLOTS];
  logic [7:0]     pt_owner_r [HEAP_SLOTS];
  logic [9:0]     pt_page_r  [HEAP_SLOTS];
  logic [8:0]     pt_free_r  [HEAP_SLOTS];

  logic [SW-1:0]  slot_r;
  logic [AW-1:0]  off_r;
  logic [AW-1:0]  off2_r;
  logic [AW-1:0]  hdr_r;
  logic [8:0]     cursz_r;
  logic [8:0]     fs_r;
  logic [8:0]     req_r;
  logic           granted_r;
  logic [9:0]     page_r;
  logic [PW-1:0]  prod_r;

  logic           out_valid_r;
  logic [2:0]     status_r;
  logic [17:0]    dptr_r;
  logic [9:0]     rel_page_r;
  logic [8:0]     freed_r;
  logic [2:0]     fin_status_r;
  logic [17:0]    out_dptr_r;
  logic [9:0]     out_rel_page_r;
  logic [8:0]     out_freed_r;

  logic [CW-1:0]  ps_ext;
  logic [CW-1:0]  ps_cl;
  logic [PSW-1:0] ps;
  logic [AW-1:0]  ps_a;
  logic [AW-1:0]  need_a;
  logic [AW-1:0]  step_a;
  logic [AW-1:0]  rptr_a;
  logic [8:0]     merged;
  logic           slot_ok;
  logic           hit;

  logic              mem_we;
  logic [SW+OW-1:0]  mem_waddr;
  pha_pkg::hdr_t     mem_wdata;
  logic [SW+OW-1:0]  mem_raddr;
  pha_pkg::hdr_t     mem_rdata;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [17:0]       div_quot;
  logic [PSW-1:0]    div_rem;

  assign ps_ext = CW'(page_size_r);
  assign ps_cl  = (ps_ext > CW'(MAX_PAGE_BYTES)) ? CW'(MAX_PAGE_BYTES) :
                  (ps_ext < CW'(2 * HEADER_BYTES)) ? CW'(2 * HEADER_BYTES) : ps_ext;
  assign ps     = PSW'(ps_cl);
  assign ps_a   = AW'(ps);

  assign need_a = AW'(req_r) + AW'(HEADER_BYTES);
  assign step_a = off_r + AW'(HEADER_BYTES) + AW'(mem_rdata.size);
  assign rptr_a = hdr_r + AW'(HEADER_BYTES) + AW'(mem_rdata.size);
  assign merged = 9'(cursz_r + mem_rdata.size + 9'(HEADER_BYTES));
  assign slot_ok = pt_valid_r[slot_r] && (pt_owner_r[slot_r] == process_id_r) &&
                   (AW'(pt_free_r[slot_r]) >= need_a);
  assign hit = mem_rdata.free && (AW'(mem_rdata.size) >= need_a);

  assign in_ready  = (state_r == S_IDLE);
  assign div_start = in_valid && in_ready && (in_operation == pha_pkg::OP_FREE);

  // Header store port control follows the sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot_r, off_r[OW-1:0]};
    mem_wdata = '0;
    mem_raddr = {slot_r, off_r[OW-1:0]};
    unique case (state_r)
      S_A_CHK: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = '{free: 1'b0, size: req_r};
        end
      end
      S_A_NEW: begin
        if (!pt_valid_r[slot_r]) begin
          mem_we    = 1'b1;
          mem_waddr = {slot_r, OW'(0)};
          mem_wdata = '{free: 1'b0, size: req_r};
        end
      end
      S_A_WR2: begin
        mem_we    = off2_r < AW'(MAX_PAGE_BYTES);
        mem_waddr = {slot_r, off2_r[OW-1:0]};
        mem_wdata = '{free: 1'b1, size: fs_r};
      end
      S_F_WALK: begin
        if (off_r >= hdr_r) begin
          mem_raddr = {slot_r, hdr_r[OW-1:0]};
        end
      end
      S_F_HCHK: begin
        mem_we    = !mem_rdata.free;
        mem_waddr = {slot_r, hdr_r[OW-1:0]};
        mem_wdata = '{free: 1'b1, size: mem_rdata.size};
        mem_raddr = {slot_r, rptr_a[OW-1:0]};
      end
      S_F_RCHK: begin
        mem_we    = mem_rdata.free;
        mem_waddr = {slot_r, hdr_r[OW-1:0]};
        mem_wdata = '{free: 1'b1, size: merged};
      end
      S_F_LCHK: begin
        mem_raddr = {slot_r, step_a[OW-1:0]};
      end
      S_F_NXCHK: begin
        mem_we    = mem_rdata.free;
        mem_wdata = '{free: 1'b1, size: merged};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_size_r  <= 9'd256;
      process_id_r <= '0;
      pc_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < HEAP_SLOTS; i++) begin
        pt_valid_r[i] <= 1'b0;
      end
    end else begin
      // The result beat is copied into its own register so that a new
      // request can run while the previous beat waits.
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r    <= 1'b1;
        status_r       <= fin_status_r;
        out_dptr_r     <= dptr_r;
        out_rel_page_r <= rel_page_r;
        out_freed_r    <= freed_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pha_pkg::CFG_PAGE_SIZE:  page_size_r  <= cfg_wdata[8:0];
          pha_pkg::CFG_PROCESS_ID: process_id_r <= cfg_wdata[7:0];
          pha_pkg::CFG_FIRST_PAGE: pc_r         <= cfg_wdata[9:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= in_request_size;
            granted_r <= in_page_granted;
            slot_r    <= '0;
            off_r     <= '0;
            dptr_r    <= '0;
            rel_page_r <= '0;
            freed_r   <= '0;
            if (in_operation == pha_pkg::OP_FREE) begin
              state_r <= S_F_DIV;
            end else if (AW'(in_request_size) > ps_a - AW'(2 * HEADER_BYTES)) begin
              fin_status_r <= pha_pkg::ST_TOO_LARGE;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_A_SCAN;
            end
          end
        end
        S_A_SCAN: begin
          off_r   <= '0;
          state_r <= slot_ok ? S_A_RD : S_A_NEXT;
        end
        S_A_NEXT: begin
          if (slot_r == LAST_SLOT) begin
            slot_r <= '0;
            if (granted_r) begin
              state_r <= S_A_NEW;
            end else begin
              fin_status_r <= pha_pkg::ST_NO_PAGE;
              state_r      <= S_DONE;
            end
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_A_SCAN;
          end
        end
        S_A_RD: begin
          state_r <= (off_r < ps_a) ? S_A_CHK : S_A_NEXT;
        end
        S_A_CHK: begin
          if (hit) begin
            off2_r  <= off_r + need_a;
            fs_r    <= 9'(AW'(mem_rdata.size) - need_a);
            pt_free_r[slot_r] <= 9'(AW'(pt_free_r[slot_r]) - need_a);
            page_r  <= pt_page_r[slot_r];
            state_r <= S_A_WR2;
          end else begin
            off_r   <= step_a;
            state_r <= S_A_RD;
          end
        end
        S_A_NEW: begin
          if (!pt_valid_r[slot_r]) begin
            pt_valid_r[slot_r] <= 1'b1;
            pt_owner_r[slot_r] <= process_id_r;
            pt_page_r[slot_r]  <= pc_r;
            pt_free_r[slot_r]  <= 9'(ps_a - AW'(2 * HEADER_BYTES) - AW'(req_r));
            off2_r  <= need_a;
            fs_r    <= 9'(ps_a - AW'(2 * HEADER_BYTES) - AW'(req_r));
            page_r  <= pc_r;
            off_r   <= '0;
            pc_r    <= pc_r + 1'b1;
            state_r <= S_A_WR2;
          end else if (slot_r == LAST_SLOT) begin
            fin_status_r <= pha_pkg::ST_NO_PAGE;
            state_r      <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_A_WR2: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PW'(page_r) * PW'(ps);
          state_r <= S_PTR;
        end
        S_PTR: begin
          dptr_r       <= 18'(prod_r + PW'(off_r) + PW'(HEADER_BYTES));
          fin_status_r <= pha_pkg::ST_ALLOCATED;
          state_r      <= S_DONE;
        end
        S_F_DIV: begin
          if (div_done) begin
            state_r <= S_F_FIND;
          end
        end
        S_F_FIND: begin
          if (pt_valid_r[slot_r] && (pt_owner_r[slot_r] == process_id_r) &&
              (18'(pt_page_r[slot_r]) == div_quot)) begin
            if (AW'(div_rem) < AW'(HEADER_BYTES)) begin
              fin_status_r <= pha_pkg::ST_NOT_OWNED;
              state_r      <= S_DONE;
            end else begin
              hdr_r   <= AW'(div_rem) - AW'(HEADER_BYTES);
              off_r   <= '0;
              state_r <= S_F_WALK;
            end
          end else if (slot_r == LAST_SLOT) begin
            fin_status_r <= pha_pkg::ST_NOT_OWNED;
            state_r      <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_F_WALK: begin
          if (off_r < hdr_r) begin
            state_r <= S_F_WCHK;
          end else if (off_r != hdr_r) begin
            fin_status_r <= pha_pkg::ST_NOT_OWNED;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_F_HCHK;
          end
        end
        S_F_WCHK: begin
          off_r   <= step_a;
          state_r <= S_F_WALK;
        end
        S_F_HCHK: begin
          if (mem_rdata.free) begin
            fin_status_r <= pha_pkg::ST_NOT_OWNED;
            state_r      <= S_DONE;
          end else begin
            cursz_r <= mem_rdata.size;
            freed_r <= mem_rdata.size;
            pt_free_r[slot_r] <= pha_pkg::sat_add(pt_free_r[slot_r], 10'(mem_rdata.size));
            off_r   <= '0;
            state_r <= (rptr_a < ps_a) ? S_F_RCHK : S_F_L;
          end
        end
        S_F_RCHK: begin
          if (mem_rdata.free) begin
            pt_free_r[slot_r] <= pha_pkg::sat_add(pt_free_r[slot_r], 10'(HEADER_BYTES));
          end
          state_r <= S_F_L;
        end
        S_F_L: begin
          state_r <= (off_r < hdr_r) ? S_F_LCHK : S_F_END;
        end
        S_F_LCHK: begin
          cursz_r <= mem_rdata.size;
          if (mem_rdata.free && (step_a < ps_a)) begin
            state_r <= S_F_NXCHK;
          end else begin
            off_r   <= step_a;
            state_r <= S_F_L;
          end
        end
        S_F_NXCHK: begin
          // After a merge the walk steps over the grown block.
          if (mem_rdata.free) begin
            pt_free_r[slot_r] <= pha_pkg::sat_add(pt_free_r[slot_r], 10'(HEADER_BYTES));
            off_r <= off_r + AW'(HEADER_BYTES) + AW'(merged);
          end else begin
            off_r <= off_r + AW'(HEADER_BYTES) + AW'(cursz_r);
          end
          state_r <= S_F_L;
        end
        S_F_END: begin
          if (AW'(pt_free_r[slot_r]) == ps_a - AW'(HEADER_BYTES)) begin
            pt_valid_r[slot_r] <= 1'b0;
            rel_page_r   <= pt_page_r[slot_r];
            fin_status_r <= pha_pkg::ST_RELEASED;
          end else begin
            fin_status_r <= pha_pkg::ST_FREED;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  pha_hdr_mem #(
    .AW(SW + OW)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pha_div #(
    .DW(18),
    .VW(PSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_block_pointer),
    .divisor  (ps),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_data_pointer  = out_dptr_r;
  assign out_released_page = out_rel_page_r;
  assign out_freed_bytes   = out_freed_r;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_div_only_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_F_DIV))
    else $error("divider busy outside the free split step");

  a_ptr_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != pha_pkg::ST_ALLOCATED)) |-> (out_data_pointer == 18'd0))
    else $error("data pointer set on a failed or free result");

  a_pc_moves_on_new_page: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_we) && (pc_r != $past(pc_r))) |->
      ($past(state_r) == S_A_NEW))
    else $error("page counter changed without a new page");
`endif

endmodule
